>>> hdl/mckd_pkg.sv
// ----------------------------------------------------------------------------
// mckd_pkg
// Shared constants and types of the multi-click key detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mckd_pkg;

    localparam int NUM_KEYS  = 5;
    localparam int NOW_W     = 32;
    localparam int LEVELS_W  = 5;
    localparam int CODE_W    = 3;
    localparam int CODES_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP  = 2'd2;

    localparam logic [CFG_DAT_W-1:0] DEBOUNCE_RST   = 16'd10;
    localparam logic [CFG_DAT_W-1:0] LONG_PRESS_RST = 16'd500;
    localparam logic [CFG_DAT_W-1:0] CLICK_GAP_RST  = 16'd50;

    typedef struct packed {
        logic [CFG_DAT_W-1:0] debounce_ms;
        logic [CFG_DAT_W-1:0] long_press_ms;
        logic [CFG_DAT_W-1:0] click_gap_ms;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/mckd_intf.sv
// ----------------------------------------------------------------------------
// mckd interfaces
// Valid/ready channels for key samples, key codes and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mckd_sample_if;
    import mckd_pkg::*;
    logic                valid;
    logic                ready;
    logic [NOW_W-1:0]    now_ms;
    logic [LEVELS_W-1:0] key_levels;
    modport source (output valid, output now_ms, output key_levels, input ready);
    modport sink   (input valid, input now_ms, input key_levels, output ready);
endinterface

interface mckd_code_if;
    import mckd_pkg::*;
    logic               valid;
    logic               ready;
    logic [CODES_W-1:0] key_codes;
    modport source (output valid, output key_codes, input ready);
    modport sink   (input valid, input key_codes, output ready);
endinterface

interface mckd_cfg_if;
    import mckd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/mckd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mckd_cfg_regs
// Timing threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mckd_cfg_regs (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mckd_cfg_if.sink    cfg,
    output mckd_pkg::cfg_t cfg_vals
);
    import mckd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_vals  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEBOUNCE:   cfg_next.debounce_ms   = cfg.data;
                REG_LONG_PRESS: cfg_next.long_press_ms = cfg.data;
                REG_CLICK_GAP:  cfg_next.click_gap_ms  = cfg.data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
            cfg_reg.click_gap_ms  <= CLICK_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mckd_key_cell.sv
// ----------------------------------------------------------------------------
// mckd_key_cell
// State and update logic of one key: debounce, long press, click counting.
// ----------------------------------------------------------------------------
`default_nettype none

module mckd_key_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic [mckd_pkg::NOW_W-1:0]  now_ms,
    input  wire logic                        pressed,
    input  wire mckd_pkg::cfg_t              cfg_vals,
    output logic      [mckd_pkg::CODE_W-1:0] code_next
);
    import mckd_pkg::*;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_HELD     = 2'd2;
    localparam logic [1:0] PH_LONG     = 2'd3;

    localparam logic [CODE_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [CODE_W-1:0] EV_LONG   = 3'd2;
    localparam logic [CODE_W-1:0] EV_DOUBLE = 3'd3;
    localparam logic [CODE_W-1:0] EV_TRIPLE = 3'd4;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    logic [1:0]        phase_reg,   phase_next;
    logic [NOW_W-1:0]  press_reg,   press_next;
    logic [NOW_W-1:0]  release_reg, release_next;
    logic [3:0]        count_reg,   count_next;
    logic [CODE_W-1:0] code_reg;

    logic [NOW_W-1:0] since_press;
    logic [NOW_W-1:0] since_release;

    assign since_press = now_ms - press_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        press_next   = press_reg;
        release_next = release_reg;
        count_next   = count_reg;
        code_next    = code_reg;

        if (pressed)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    press_next = now_ms;
                    phase_next = PH_DEBOUNCE;
                end
                PH_DEBOUNCE:
                begin
                    if (since_press >= {16'd0, cfg_vals.debounce_ms})
                    begin
                        press_next = now_ms;
                        phase_next = PH_HELD;
                    end
                end
                PH_HELD:
                begin
                    if (since_press >= {16'd0, cfg_vals.long_press_ms})
                    begin
                        phase_next = PH_LONG;
                        code_next  = EV_LONG;
                        count_next = 4'd0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else
        begin
            if (phase_reg == PH_HELD)
            begin
                release_next = now_ms;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 4'd1;
                end
            end
            phase_next = PH_IDLE;
        end

        // The gap check sees the release stamp and count of this same sample.
        since_release = now_ms - release_next;
        if ((count_next != 4'd0) && (since_release >= {16'd0, cfg_vals.click_gap_ms}))
        begin
            case (count_next)
                4'd1:    code_next = EV_SINGLE;
                4'd2:    code_next = EV_DOUBLE;
                4'd3:    code_next = EV_TRIPLE;
                default: code_next = code_next;
            endcase
            count_next = 4'd0;
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            press_reg   <= '0;
            release_reg <= '0;
            count_reg   <= '0;
            code_reg    <= '0;
        end
        else if (en)
        begin
            phase_reg   <= phase_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            count_reg   <= count_next;
            code_reg    <= code_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/multi_click_key_detector.sv
// ----------------------------------------------------------------------------
// multi_click_key_detector
// Per-key debounce, long-press and multi-click detection on sampled levels.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one transaction per millisecond sample, carrying now_ms and
//             key_levels (active low, one bit per key).
//   codes   : one transaction per sample, carrying key_codes with three bits
//             per key (0 none, 1 single, 2 long, 3 double, 4 triple).
//   cfg     : register writes (0 debounce, 1 long press, 2 click gap), always
//             ready; write only while no sample is in flight.
//   A sample lands in the input register. When the output register is empty or
//   being read, the key cells update and the output register loads on the same
//   edge. One sample per cycle is sustained while codes.ready stays high; the
//   rate is set by the single pass through the key cell update logic.
//   When the codes receiver stalls, the output register holds its result and
//   an empty input register takes one more sample; then samples.ready drops.
//   Reset restores the default thresholds (10, 500, 50 ms), returns every key
//   to idle with no clicks pending and no code, and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_click_key_detector (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mckd_sample_if.sink samples,
    mckd_code_if.source codes,
    mckd_cfg_if.sink    cfg
);
    import mckd_pkg::*;

    cfg_t cfg_vals;

    logic                in_valid_reg, in_valid_next;
    logic [NOW_W-1:0]    in_now_reg;
    logic [LEVELS_W-1:0] in_levels_reg;
    logic                out_valid_reg, out_valid_next;
    logic [CODES_W-1:0]  out_codes_reg, codes_next;

    logic in_take;
    logic advance;

    logic [CODE_W-1:0] key_code [NUM_KEYS];

    assign advance       = in_valid_reg && (!out_valid_reg || codes.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign in_take       = samples.valid && samples.ready;

    assign codes.valid     = out_valid_reg;
    assign codes.key_codes = out_codes_reg;

    mckd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        mckd_key_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .now_ms    (in_now_reg),
            .pressed   (!in_levels_reg[k]),
            .cfg_vals  (cfg_vals),
            .code_next (key_code[k])
        );
    end

    always_comb
    begin
        codes_next = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            codes_next[CODE_W*k +: CODE_W] = key_code[k];
        end
    end

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (codes.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_now_reg    <= samples.now_ms;
            in_levels_reg <= samples.key_levels;
        end
        if (advance)
        begin
            out_codes_reg <= codes_next;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_multi_click_key_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_click_key_detector
// Self-checking bench for the multi-click key detector. A short directed
// sequence covers long press, double, triple and four-click runs, gap expiry
// while a key is held, bounces and timestamp wrap. It is followed by random
// press/release runs under several threshold settings and handshake pressure.
// Every key code transaction is compared with a behavioral prediction.
// ----------------------------------------------------------------------------

module tb_multi_click_key_detector;

    import mckd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_DEBOUNCE,
        KEY_HELD,
        KEY_LONG
    } key_phase_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_NONE   = 3'd0,
        CODE_SINGLE = 3'd1,
        CODE_LONG   = 3'd2,
        CODE_DOUBLE = 3'd3,
        CODE_TRIPLE = 3'd4
    } key_code_t;

    // Predicts key_codes for every accepted sample and checks the results.
    class key_code_tracker_t;
        logic [CFG_DAT_W-1:0] deb_ms = DEBOUNCE_RST;
        logic [CFG_DAT_W-1:0] long_ms = LONG_PRESS_RST;
        logic [CFG_DAT_W-1:0] gap_ms = CLICK_GAP_RST;
        key_phase_t phase [NUM_KEYS];
        logic [NOW_W-1:0] press_at [NUM_KEYS];
        logic [NOW_W-1:0] release_at [NUM_KEYS];
        logic [3:0] clicks [NUM_KEYS];
        key_code_t code [NUM_KEYS];
        logic [CODES_W-1:0] pending_codes [$];
        int mismatches = 0;

        function void clear_keys();
            int k;
            for (k = 0; k < NUM_KEYS; k++)
            begin
                phase[k] = KEY_IDLE;
                press_at[k] = '0;
                release_at[k] = '0;
                clicks[k] = '0;
                code[k] = CODE_NONE;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_DEBOUNCE:   deb_ms = val;
                REG_LONG_PRESS: long_ms = val;
                REG_CLICK_GAP:  gap_ms = val;
                default:        ;
            endcase
        endfunction

        function void take_sample(logic [NOW_W-1:0] now, logic [LEVELS_W-1:0] lv);
            int k;
            logic [NOW_W-1:0] elapsed;
            logic [CODES_W-1:0] word;
            word = '0;
            for (k = 0; k < NUM_KEYS; k++)
            begin
                if (!lv[k])
                begin
                    elapsed = now - press_at[k];
                    case (phase[k])
                        KEY_IDLE:
                        begin
                            press_at[k] = now;
                            phase[k] = KEY_DEBOUNCE;
                        end
                        KEY_DEBOUNCE:
                        begin
                            if (elapsed >= {16'd0, deb_ms})
                            begin
                                press_at[k] = now;
                                phase[k] = KEY_HELD;
                            end
                        end
                        KEY_HELD:
                        begin
                            if (elapsed >= {16'd0, long_ms})
                            begin
                                phase[k] = KEY_LONG;
                                code[k] = CODE_LONG;
                                clicks[k] = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    // Only a release out of a debounced press counts as a click.
                    if (phase[k] == KEY_HELD)
                    begin
                        release_at[k] = now;
                        if (clicks[k] != 4'd15)
                            clicks[k] = clicks[k] + 4'd1;
                    end
                    phase[k] = KEY_IDLE;
                end

                elapsed = now - release_at[k];
                if (clicks[k] != 0 && elapsed >= {16'd0, gap_ms})
                begin
                    // Four or more clicks leave the previous code in place.
                    case (clicks[k])
                        4'd1:    code[k] = CODE_SINGLE;
                        4'd2:    code[k] = CODE_DOUBLE;
                        4'd3:    code[k] = CODE_TRIPLE;
                        default: ;
                    endcase
                    clicks[k] = '0;
                    phase[k] = KEY_IDLE;
                end
                word[CODE_W*k +: CODE_W] = code[k];
            end
            pending_codes.push_back(word);
        endfunction

        function void check_codes(logic [CODES_W-1:0] got);
            logic [CODES_W-1:0] want;
            if (pending_codes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected key_codes transaction: expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_codes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: key_codes mismatch: expected %h, actual %h",
                         $time, want, got);
            end
        endfunction

        function int outstanding();
            return pending_codes.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mckd_sample_if sample_ch ();
    mckd_code_if   code_ch ();
    mckd_cfg_if    cfg_ch ();

    multi_click_key_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .codes   (code_ch),
        .cfg     (cfg_ch)
    );

    key_code_tracker_t tracker = new;

    // Stimulus shaping, owned by the main process.
    int unsigned src_idle_pct = 0;
    int unsigned step_max = 1;
    int unsigned span_ms = 1;
    int unsigned short_rel_pct = 70;
    int unsigned jump_pct = 0;
    logic [NOW_W-1:0] clock_ms = '0;

    // Per-key press/release runs of the random part.
    logic run_lvl [NUM_KEYS];
    logic [NOW_W-1:0] run_start [NUM_KEYS];
    int unsigned run_len [NUM_KEYS];

    // Receiver control.
    int unsigned snk_stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left = 0;
    int unsigned cycles = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Code receiver with random stalls and an occasional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && code_ch.valid && code_ch.ready)
            tracker.check_codes(code_ch.key_codes);
        if (hold_reqs != hold_taken)
        begin
            hold_taken <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            code_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            code_ch.ready <= 1'b0;
        end
        else
        begin
            code_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    task automatic send_sample(logic [NOW_W-1:0] now, logic [LEVELS_W-1:0] lv);
        if (src_idle_pct > 0)
        begin
            while ($urandom_range(0, 99) < src_idle_pct)
            begin
                sample_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample_ch.valid <= 1'b1;
        sample_ch.now_ms <= now;
        sample_ch.key_levels <= lv;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        tracker.take_sample(now, lv);
    endtask

    // Stop offering samples and wait until the block has nothing in flight.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_thresholds(int unsigned deb, int unsigned lng, int unsigned gap,
                                   bit with_unused);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DAT_W-1:0] val [4];
        int n;
        int i;
        idx[0] = REG_DEBOUNCE;   val[0] = deb[15:0];
        idx[1] = REG_LONG_PRESS; val[1] = lng[15:0];
        idx[2] = REG_CLICK_GAP;  val[2] = gap[15:0];
        idx[3] = REG_UNUSED;     val[3] = CFG_DAT_W'($urandom);
        n = with_unused ? 4 : 3;
        for (i = 0; i < n; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data <= val[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            tracker.write_reg(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int unsigned capped(int unsigned x);
        return (x < span_ms) ? x : span_ms;
    endfunction

    // Duration in ms of the next run: bounces, clicks and long presses for a
    // press, short gaps that chain clicks or long gaps that end them for a release.
    function automatic int unsigned run_length(logic released);
        int unsigned deb;
        int unsigned lng;
        int unsigned gap;
        int unsigned pick;
        deb = tracker.deb_ms;
        lng = tracker.long_ms;
        gap = tracker.gap_ms;
        pick = $urandom_range(0, 99);
        if (released)
        begin
            if (pick < short_rel_pct)
                return $urandom_range(0, capped(gap));
            return gap + $urandom_range(0, span_ms);
        end
        if (pick < 15)
            return (deb == 0) ? 0 : $urandom_range(0, capped(deb) - 1);
        if (pick < 75)
            return deb + $urandom_range(0, capped(lng));
        return deb + lng + $urandom_range(0, span_ms);
    endfunction

    task automatic random_samples(int count);
        logic [LEVELS_W-1:0] lv;
        int k;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < jump_pct)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(1, step_max);
            for (k = 0; k < NUM_KEYS; k++)
            begin
                if (clock_ms - run_start[k] >= run_len[k])
                begin
                    run_lvl[k] = ~run_lvl[k];
                    run_start[k] = clock_ms;
                    run_len[k] = run_length(run_lvl[k]);
                end
                lv[k] = run_lvl[k];
            end
            // A little level noise breaks up otherwise clean sequences.
            if ($urandom_range(0, 99) < 3)
                lv = LEVELS_W'($urandom);
            send_sample(clock_ms, lv);
        end
    endtask

    task automatic run_phase(int unsigned deb, int unsigned lng, int unsigned gap,
                             int unsigned src_pct, int unsigned snk_pct, int count,
                             int unsigned step, int unsigned span,
                             int unsigned short_pct, int unsigned jumps, bit hold);
        drain();
        load_thresholds(deb, lng, gap, hold);
        src_idle_pct = src_pct;
        snk_stall_pct <= snk_pct;
        step_max = step;
        span_ms = span;
        short_rel_pct = short_pct;
        jump_pct = jumps;
        if (hold)
            hold_reqs <= hold_reqs + 1;
        random_samples(count);
    endtask

    initial
    begin
        string pat [NUM_KEYS];
        logic [LEVELS_W-1:0] lv;
        int i;
        int k;

        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.now_ms = '0;
        sample_ch.key_levels = '1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_DEBOUNCE;
        cfg_ch.data = '0;
        tracker.clear_keys();
        for (k = 0; k < NUM_KEYS; k++)
        begin
            run_lvl[k] = 1'b1;
            run_start[k] = '0;
            run_len[k] = 0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, '0' is a pressed sample. Key 0 clicks four times,
        // key 1 long-presses then clicks once, key 2 double-clicks and is still
        // held when the gap runs out, key 3 triple-clicks and key 4 bounces.
        pat[0] = "001001001001111111111111";
        pat[1] = "000000000100111111111111";
        pat[2] = "001001000000011111111111";
        pat[3] = "001001001111111111111111";
        pat[4] = "010101010101111111111111";
        load_thresholds(0, 6, 4, 1'b0);
        clock_ms = 32'hFFFF_FFF8;
        for (i = 0; i < 24; i++)
        begin
            for (k = 0; k < NUM_KEYS; k++)
                lv[k] = (pat[k].getc(i) == "1");
            send_sample(clock_ms, lv);
            clock_ms = clock_ms + 1;
        end

        run_phase(10, 500, 50, 62, 0, 350, 8, 400, 70, 0, 1'b0);
        run_phase(3, 20, 8, 0, 62, 400, 3, 30, 70, 1, 1'b0);
        run_phase(0, 0, 0, 28, 28, 250, 2, 6, 50, 1, 1'b1);
        run_phase(65535, 65535, 65535, 0, 0, 200, 4000, 60000, 60, 1, 1'b0);
        // Long gap with fast clicks drives the click count into saturation.
        run_phase(1, 2, 65535, 62, 0, 350, 2, 4, 100, 2, 1'b0);
        run_phase($urandom_range(0, 20), $urandom_range(0, 60), $urandom_range(0, 30),
                  0, 62, 250, 5, 50, 70, 1, 1'b0);
        run_phase(5, 30, 12, 0, 0, 250, 2, 40, 70, 1, 1'b1);
        drain();

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hdl/mckd_pkg.sv
hdl/mckd_intf.sv
hdl/mckd_cfg_regs.sv
hdl/mckd_key_cell.sv
hdl/multi_click_key_detector.sv
verif/tb_multi_click_key_detector.sv
